// ----- hw/rtl/gcrs_pkg.sv -----
// Shared types and constants for the gradient colour ramp sampler.
package gcrs_pkg;

    localparam int POS_W   = 16;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 4;
    localparam int COLOR_W = CH_W * NUM_CH;
    localparam int ENTRY_W = POS_W + COLOR_W;
    localparam int CNT_W   = 5;
    localparam int ACC_W   = POS_W + CH_W;
    localparam int STEP_W  = 3;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } gcrs_state_t;

endpackage

// ----- hw/rtl/gradient_color_ramp_sampler_top.sv -----
// Gradient colour ramp sampler: stop table, scan sequencer and bit-serial blend lanes.
//
//   channel   direction   handshake               contents
//   input     in          in_valid / in_stall     func, stop_index, stop_*, factor
//   output    out         out_valid / out_stall   insert_index, result_position, out_*, color_valid
//   config    in          cfg_wr_en               cfg_wr_data -> stop_count
//
// One word at a time. In a sample the table scan reads one stop per cycle from the registered
// stop memory; when it blends it then runs 8 shift-add steps then 8 restoring divide steps,
// one bit each, in four colour lanes side by side.
// Reset clears the control state and stop_count; the stop table holds no reset value.
// A finished word waits in the output register while the next word is taken.
module gradient_color_ramp_sampler_top
    import gcrs_pkg::*;
#(
    parameter int MAX_STOPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [3:0]           stop_index,
    input  logic [POS_W-1:0]     stop_position,
    input  logic [CH_W-1:0]      stop_red,
    input  logic [CH_W-1:0]      stop_green,
    input  logic [CH_W-1:0]      stop_blue,
    input  logic [CH_W-1:0]      stop_alpha,
    input  logic [POS_W-1:0]     factor,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CNT_W-1:0]     insert_index,
    output logic [POS_W-1:0]     result_position,
    output logic [CH_W-1:0]      out_red,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_blue,
    output logic [CH_W-1:0]      out_alpha,
    output logic                 color_valid
);

    localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

    gcrs_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   stop_count_reg;
    logic [CNT_W-1:0]   count;
    logic               in_accept;
    logic               out_free;

    logic [ENTRY_W-1:0] mem [MAX_STOPS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic [CNT_W-1:0]   k_reg;
    logic [POS_W-1:0]   factor_reg;
    logic [POS_W-1:0]   prev_pos_reg;
    logic [COLOR_W-1:0] prev_color_reg;
    logic [POS_W-1:0]   pos_k;
    logic [COLOR_W-1:0] color_k;
    logic               first;
    logic               take_first;
    logic               hit;
    logic               is_last;
    logic [POS_W-1:0]   d_val;
    logic [POS_W-1:0]   n_val;

    logic [STEP_W-1:0]  step_reg;
    logic [ACC_W-1:0]   dn_sh_reg;
    logic [ACC_W-1:0]   n_sh_reg;
    logic [ACC_W-1:0]   d_sh_reg;
    logic [CH_W-1:0]    a_sh_reg [NUM_CH];
    logic [CH_W-1:0]    b_sh_reg [NUM_CH];
    logic [ACC_W-1:0]   acc_reg  [NUM_CH];
    logic [CH_W-1:0]    q_reg    [NUM_CH];
    logic [ACC_W-1:0]   acc_mul  [NUM_CH];
    logic [ACC_W-1:0]   acc_div  [NUM_CH];
    logic [CH_W-1:0]    q_next   [NUM_CH];

    logic [CNT_W-1:0]   res_index_reg;
    logic [POS_W-1:0]   res_pos_reg;
    logic [COLOR_W-1:0] res_color_reg;
    logic               res_valid_reg;

    logic               out_valid_reg;
    logic [CNT_W-1:0]   out_index_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_cvalid_reg;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign count     = (32'(stop_count_reg) > MAX_STOPS) ? CNT_W'(MAX_STOPS) : stop_count_reg;

    assign pos_k      = rd_data_reg[ENTRY_W-1:COLOR_W];
    assign color_k    = rd_data_reg[COLOR_W-1:0];
    assign first      = (k_reg == '0);
    assign take_first = first && ((count == CNT_W'(1)) || (factor_reg == '0));
    assign hit        = (factor_reg < pos_k);
    assign is_last    = (k_reg == CNT_W'(count - CNT_W'(1)));
    assign d_val      = pos_k - prev_pos_reg;
    assign n_val      = factor_reg - prev_pos_reg;
    assign rd_addr    = (state_reg == ST_FETCH) ? '0 : IDX_W'(CNT_W'(k_reg + CNT_W'(1)));

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            stop_count_reg <= cfg_wr_data;
        end
    end

    // stop table
    always_ff @(posedge clk)
    begin
        if (in_accept && (func == FUNC_WRITE) && (32'(stop_index) < MAX_STOPS))
        begin
            mem[IDX_W'(stop_index)] <= {stop_position, stop_alpha, stop_blue, stop_green,
                                        stop_red};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if ((func == FUNC_WRITE) || (count == '0))
                        state_next = ST_FIN;
                    else
                        state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (take_first)
                    state_next = ST_FIN;
                else if (hit)
                    state_next = first ? ST_FIN : ST_MUL;
                else if (is_last)
                    state_next = ST_FIN;
            end
            ST_MUL:
            begin
                if (step_reg == '1)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == '1)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            acc_mul[i] = acc_reg[i] + (a_sh_reg[i][0] ? dn_sh_reg : '0)
                                    + (b_sh_reg[i][0] ? n_sh_reg : '0);
            if (acc_reg[i] >= d_sh_reg)
            begin
                acc_div[i] = acc_reg[i] - d_sh_reg;
                q_next[i]  = {q_reg[i][CH_W-2:0], 1'b1};
            end
            else
            begin
                acc_div[i] = acc_reg[i];
                q_next[i]  = {q_reg[i][CH_W-2:0], 1'b0};
            end
        end
    end

    // scan and blend datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                factor_reg    <= factor;
                k_reg         <= '0;
                res_index_reg <= '0;
                res_pos_reg   <= '0;
                res_color_reg <= '0;
                res_valid_reg <= 1'b0;
            end
            ST_SCAN:
            begin
                prev_pos_reg   <= pos_k;
                prev_color_reg <= color_k;
                k_reg          <= CNT_W'(k_reg + CNT_W'(1));
                step_reg       <= '0;
                dn_sh_reg      <= ACC_W'(POS_W'(d_val - n_val));
                n_sh_reg       <= ACC_W'(n_val);
                d_sh_reg       <= ACC_W'({d_val, {(CH_W-1){1'b0}}});
                for (int i = 0; i < NUM_CH; i++)
                begin
                    a_sh_reg[i] <= prev_color_reg[i*CH_W +: CH_W];
                    b_sh_reg[i] <= color_k[i*CH_W +: CH_W];
                    acc_reg[i]  <= ACC_W'(d_val >> 1);
                    q_reg[i]    <= '0;
                end
                if (take_first)
                begin
                    res_index_reg <= '0;
                    res_pos_reg   <= pos_k;
                    res_color_reg <= color_k;
                    res_valid_reg <= 1'b1;
                end
                else if (hit)
                begin
                    res_index_reg <= k_reg;
                    res_pos_reg   <= factor_reg;
                    res_color_reg <= color_k;
                    res_valid_reg <= 1'b1;
                end
                else if (is_last)
                begin
                    res_index_reg <= count;
                    res_pos_reg   <= pos_k;
                    res_color_reg <= color_k;
                    res_valid_reg <= 1'b1;
                end
            end
            ST_MUL:
            begin
                step_reg  <= STEP_W'(step_reg + STEP_W'(1));
                dn_sh_reg <= {dn_sh_reg[ACC_W-2:0], 1'b0};
                n_sh_reg  <= {n_sh_reg[ACC_W-2:0], 1'b0};
                for (int i = 0; i < NUM_CH; i++)
                begin
                    acc_reg[i]  <= acc_mul[i];
                    a_sh_reg[i] <= {1'b0, a_sh_reg[i][CH_W-1:1]};
                    b_sh_reg[i] <= {1'b0, b_sh_reg[i][CH_W-1:1]};
                end
            end
            ST_DIV:
            begin
                step_reg <= STEP_W'(step_reg + STEP_W'(1));
                d_sh_reg <= {1'b0, d_sh_reg[ACC_W-1:1]};
                for (int i = 0; i < NUM_CH; i++)
                begin
                    acc_reg[i] <= acc_div[i];
                    q_reg[i]   <= q_next[i];
                    res_color_reg[i*CH_W +: CH_W] <= q_next[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_index_reg  <= res_index_reg;
            out_pos_reg    <= res_pos_reg;
            out_color_reg  <= res_color_reg;
            out_cvalid_reg <= res_valid_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign insert_index    = out_index_reg;
    assign result_position = out_pos_reg;
    assign out_red         = out_color_reg[0*CH_W +: CH_W];
    assign out_green       = out_color_reg[1*CH_W +: CH_W];
    assign out_blue        = out_color_reg[2*CH_W +: CH_W];
    assign out_alpha       = out_color_reg[3*CH_W +: CH_W];
    assign color_valid     = out_cvalid_reg;

endmodule

// ----- bench/ramp_sample_checker.sv -----
// Checker for the gradient colour ramp sampler: predicts each result word and compares it.
module ramp_sample_checker
    import gcrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CNT_W-1:0]   cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               func,
    input  logic [3:0]         stop_index,
    input  logic [POS_W-1:0]   stop_position,
    input  logic [CH_W-1:0]    stop_red,
    input  logic [CH_W-1:0]    stop_green,
    input  logic [CH_W-1:0]    stop_blue,
    input  logic [CH_W-1:0]    stop_alpha,
    input  logic [POS_W-1:0]   factor,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [CNT_W-1:0]   insert_index,
    input  logic [POS_W-1:0]   result_position,
    input  logic [CH_W-1:0]    out_red,
    input  logic [CH_W-1:0]    out_green,
    input  logic [CH_W-1:0]    out_blue,
    input  logic [CH_W-1:0]    out_alpha,
    input  logic               color_valid,
    output int                 fail_count,
    output int                 pending_count
);

    localparam int RAMP_DEPTH = 16;
    localparam int SLOT_W     = $clog2(RAMP_DEPTH);
    localparam int PRINT_CAP  = 100;

    typedef struct packed {
        logic [CNT_W-1:0] insert_index;
        logic [POS_W-1:0] position;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic             valid;
    } ramp_word_t;

    logic [POS_W-1:0]   stop_pos [RAMP_DEPTH];
    logic [COLOR_W-1:0] stop_col [RAMP_DEPTH];
    logic [CNT_W-1:0]   stop_cnt = '0;
    ramp_word_t         ramp_due [$];
    ramp_word_t         head;

    function automatic logic [CH_W-1:0] mix_channel(input int unsigned lo, input int unsigned hi,
                                                    input int unsigned n, input int unsigned d);
        return CH_W'((lo * (d - n) + hi * n + d / 2) / d);
    endfunction

    function automatic ramp_word_t ramp_at(input logic [POS_W-1:0] f);
        ramp_word_t         w;
        int unsigned        live, k, j, d, n;
        logic [COLOR_W-1:0] lo, hi, mix;
        w    = '0;
        live = (stop_cnt > RAMP_DEPTH) ? RAMP_DEPTH : stop_cnt;
        if (live == 0)
            return w;
        w.valid = 1'b1;
        if (live == 1 || f == 0)
        begin
            w.position = stop_pos[0];
            {w.alpha, w.blue, w.green, w.red} = stop_col[0];
            return w;
        end
        for (k = 0; k < live; k++)
        begin
            if (f < stop_pos[SLOT_W'(k)])
            begin
                w.insert_index = CNT_W'(k);
                w.position     = f;
                if (k == 0)
                    mix = stop_col[0];
                else
                begin
                    lo = stop_col[SLOT_W'(k-1)];
                    hi = stop_col[SLOT_W'(k)];
                    d  = stop_pos[SLOT_W'(k)] - stop_pos[SLOT_W'(k-1)];
                    n  = f - stop_pos[SLOT_W'(k-1)];
                    for (j = 0; j < NUM_CH; j++)
                        mix[j*CH_W +: CH_W] = mix_channel(lo[j*CH_W +: CH_W],
                                                          hi[j*CH_W +: CH_W], n, d);
                end
                {w.alpha, w.blue, w.green, w.red} = mix;
                return w;
            end
        end
        w.insert_index = CNT_W'(live);
        w.position     = stop_pos[SLOT_W'(live-1)];
        {w.alpha, w.blue, w.green, w.red} = stop_col[SLOT_W'(live-1)];
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("ramp mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_cnt = '0;
            ramp_due.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (ramp_due.size() == 0)
                    report_mismatch("result word with nothing outstanding");
                else
                begin
                    head = ramp_due.pop_front();
                    if (insert_index !== head.insert_index)
                        report_mismatch($sformatf("insert_index %0d, expected %0d",
                                                  insert_index, head.insert_index));
                    if (result_position !== head.position)
                        report_mismatch($sformatf("result_position %h, expected %h",
                                                  result_position, head.position));
                    if (out_red !== head.red)
                        report_mismatch($sformatf("out_red %h, expected %h", out_red, head.red));
                    if (out_green !== head.green)
                        report_mismatch($sformatf("out_green %h, expected %h",
                                                  out_green, head.green));
                    if (out_blue !== head.blue)
                        report_mismatch($sformatf("out_blue %h, expected %h", out_blue, head.blue));
                    if (out_alpha !== head.alpha)
                        report_mismatch($sformatf("out_alpha %h, expected %h",
                                                  out_alpha, head.alpha));
                    if (color_valid !== head.valid)
                        report_mismatch($sformatf("color_valid %b, expected %b",
                                                  color_valid, head.valid));
                end
            end
            if (cfg_wr_en)
                stop_cnt = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                if (func == FUNC_WRITE)
                begin
                    stop_pos[stop_index] = stop_position;
                    stop_col[stop_index] = {stop_alpha, stop_blue, stop_green, stop_red};
                    ramp_due.push_back('0);
                end
                else
                    ramp_due.push_back(ramp_at(factor));
            end
            pending_count = ramp_due.size();
        end
    end

endmodule

// ----- bench/gradient_color_ramp_sampler_top_tb.sv -----
// Stimulus and verdict for the gradient colour ramp sampler, checked by ramp_sample_checker.
module gradient_color_ramp_sampler_top_tb;
    import gcrs_pkg::*;

    localparam int WORD_TARGET  = 1700;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [CNT_W-1:0]   cfg_wr_data   = '0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic               func          = FUNC_WRITE;
    logic [3:0]         stop_index    = '0;
    logic [POS_W-1:0]   stop_position = '0;
    logic [CH_W-1:0]    stop_red      = '0;
    logic [CH_W-1:0]    stop_green    = '0;
    logic [CH_W-1:0]    stop_blue     = '0;
    logic [CH_W-1:0]    stop_alpha    = '0;
    logic [POS_W-1:0]   factor        = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [CNT_W-1:0]   insert_index;
    logic [POS_W-1:0]   result_position;
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [CH_W-1:0]    out_alpha;
    logic               color_valid;

    int                 fail_count;
    int                 pending_count;
    int unsigned        words_sent   = 0;
    int unsigned        idle_run     = 0;
    int unsigned        live_stops   = 0;
    bit                 tx_burst     = 1'b0;
    bit                 rx_no_stall  = 1'b0;
    bit                 rx_hold_req  = 1'b0;
    logic [POS_W-1:0]   ramp_pos [16];

    gradient_color_ramp_sampler_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .stop_index      (stop_index),
        .stop_position   (stop_position),
        .stop_red        (stop_red),
        .stop_green      (stop_green),
        .stop_blue       (stop_blue),
        .stop_alpha      (stop_alpha),
        .factor          (factor),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .insert_index    (insert_index),
        .result_position (result_position),
        .out_red         (out_red),
        .out_green       (out_green),
        .out_blue        (out_blue),
        .out_alpha       (out_alpha),
        .color_valid     (color_valid)
    );

    ramp_sample_checker u_ramp_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .stop_index      (stop_index),
        .stop_position   (stop_position),
        .stop_red        (stop_red),
        .stop_green      (stop_green),
        .stop_blue       (stop_blue),
        .stop_alpha      (stop_alpha),
        .factor          (factor),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .insert_index    (insert_index),
        .result_position (result_position),
        .out_red         (out_red),
        .out_green       (out_green),
        .out_blue        (out_blue),
        .out_alpha       (out_alpha),
        .color_valid     (color_valid),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run <= 0;
        else if (idle_run == STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                hold        = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            else
                hold = rx_no_stall ? 0 : $urandom_range(0, 16);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic offer_word(input logic op, input logic [3:0] idx, input logic [POS_W-1:0] pos,
                              input logic [COLOR_W-1:0] col, input logic [POS_W-1:0] fac);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func          <= op;
        stop_index    <= idx;
        stop_position <= pos;
        {stop_alpha, stop_blue, stop_green, stop_red} <= col;
        factor        <= fac;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic load_stop(input logic [3:0] idx, input logic [POS_W-1:0] pos,
                             input logic [COLOR_W-1:0] col);
        ramp_pos[idx] = pos;
        offer_word(FUNC_WRITE, idx, pos, col, POS_W'($urandom()));
    endtask

    task automatic probe(input logic [POS_W-1:0] fac);
        offer_word(FUNC_SAMPLE, 4'($urandom()), POS_W'($urandom()), $urandom(), fac);
    endtask

    task automatic set_stop_count(input logic [CNT_W-1:0] c);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        live_stops = (c > 16) ? 16 : c;
    endtask

    function automatic logic [POS_W-1:0] pick_factor();
        logic [POS_W-1:0] near;
        near = (live_stops != 0) ? ramp_pos[4'($urandom_range(0, live_stops - 1))]
                                 : POS_W'($urandom());
        case ($urandom_range(0, 5))
            0: return near;
            1: return near + POS_W'(1);
            2: return near - POS_W'(1);
            3: return $urandom_range(0, 1) ? '1 : '0;
            default: return POS_W'($urandom());
        endcase
    endfunction

    task automatic load_ramp(input int unsigned n);
        int unsigned spots [$];
        int unsigned spread, base;
        bit          ordered;
        ordered = ($urandom_range(0, 5) != 0);
        spread  = $urandom_range(0, 1) ? 65535 : 4 * n + 1;
        base    = $urandom_range(0, 65535 - spread);
        repeat (n) spots.push_back(base + $urandom_range(0, spread));
        if (ordered)
            spots.sort();
        if (ordered && n > 1 && $urandom_range(0, 2) == 0)
        begin
            spots[0]   = 0;
            spots[n-1] = 65535;
        end
        foreach (spots[i])
            load_stop(4'(i), POS_W'(spots[i]), $urandom());
    endtask

    initial
    begin
        int unsigned phase, c;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        probe(16'h0000);
        probe(16'hFFFF);
        load_stop(4'd0, 16'h1000, 32'h0000_0000);
        load_stop(4'd1, 16'h4000, 32'hFFFF_FFFF);
        load_stop(4'd2, 16'h8000, 32'h80C0_4001);
        load_stop(4'd3, 16'h8002, 32'h7F3F_41FE);
        load_stop(4'd15, 16'hFFFF, 32'hFFFF_FFFF);
        set_stop_count(5'd1);
        probe(16'h8000);
        set_stop_count(5'd4);
        probe(16'h0000);
        probe(16'h0800);
        probe(16'h2800);
        probe(16'h4000);
        probe(16'h8001);
        probe(16'hFFFE);
        probe(16'hFFFF);

        phase = 0;
        while (words_sent < WORD_TARGET)
        begin
            case (phase)
                0: c = 16;
                1: c = 0;
                2: c = 1;
                3: c = 2;
                4: c = 31;
                default: c = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                          : $urandom_range(0, 16);
            endcase
            tx_burst    = (phase == 5) || ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            set_stop_count(CNT_W'(c));
            rx_hold_req = (phase == 5);
            load_ramp(live_stops);
            repeat ($urandom_range(20, 60))
            begin
                if ($urandom_range(0, 9) == 0)
                    load_stop(4'($urandom()), POS_W'($urandom()), $urandom());
                else
                    probe(pick_factor());
            end
            phase++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
